>>> rtl/slri_pkg.sv
// Package for the sorted list insert/remove block.
// Holds the transaction structs, status and request codes, and the cell interface types.
// No dependencies.
package slri_pkg;

  // Request kinds carried in the input transaction
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CMP   = 2'd1,
    S_APPLY = 2'd2
  } state_e;

  // Input transaction
  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] value;
  } req_t;

  // Output transaction
  typedef struct packed {
    status_e    status;
    logic [4:0] entry_count;
  } rsp_t;

  // Broadcast command from the sequencer to every cell
  typedef struct packed {
    logic               cmp_en;  // latch compare flags against value
    logic               ins_en;  // perform insert shift (list not full)
    logic               rem_en;  // perform remove shift (match found)
    logic signed [31:0] value;
  } cmd_t;

  // What a cell shows its neighbors and the sequencer
  typedef struct packed {
    logic               gt_occ;  // occupied and entry > value
    logic               eq_occ;  // occupied and entry == value
    logic signed [31:0] entry;
  } cell_out_t;

endpackage

>>> rtl/sorted_list_insert_remove.sv
// Sorted list top level: sequencer, fill count, result register, chain of cells.
// An accepted request passes the compare state, then the apply state, which waits while the
// output is stalled; the result is then registered. No new request is taken until then.
// A new request is taken while the previous result still waits at the output.
// Reset: asynchronous, active low; clears the fill count, sequencer and output valid.
// List entries are not cleared; only positions below the fill count are ever used.
module sorted_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slri_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slri_pkg::rsp_t out_rsp_o
);
  import slri_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  req_t            req_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  rsp_t            rsp_q;
  logic            in_acc, apply_go, full, found;
  cmd_t            cmd;
  cell_out_t       cells [DEPTH];
  logic [DEPTH-1:0] eq_vec;
  logic [CntW+4:0] count_ext;
  status_e         status;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign apply_go = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);
  assign full     = count_q == CntW'(DEPTH);

  // Any occupied cell matching the value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq_vec[i] = cells[i].eq_occ;
    end
  end
  assign found = |eq_vec;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: if (apply_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    cmd.cmp_en = 1'b0;
    cmd.ins_en = 1'b0;
    cmd.rem_en = 1'b0;
    cmd.value  = req_q.value;
    case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_CMP:   cmd.cmp_en = 1'b1;
      S_APPLY: begin
        cmd.ins_en = apply_go && (req_q.req_type == REQ_INSERT) && !full;
        cmd.rem_en = apply_go && (req_q.req_type == REQ_REMOVE) && found;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (cmd.ins_en) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result status
  always_comb begin
    status = ST_OK;
    if (req_q.req_type == REQ_INSERT) begin
      if (full) status = ST_FULL;
    end else begin
      if (!found) status = ST_NOT_FOUND;
    end
  end

  assign count_ext = {5'b0, count_d};

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      rsp_q.status      <= status;
      rsp_q.entry_count <= count_ext[4:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_out_t left_c, right_c;
    if (g == 0) begin : g_first
      assign left_c = '0;
    end else begin : g_mid_l
      assign left_c = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_c = cells[g];
    end else begin : g_mid_r
      assign right_c = cells[g+1];
    end
    slri_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .left_i  (left_c),
      .right_i (right_c),
      .cell_o  (cells[g])
    );
  end

`ifndef NO_ASSERTIONS
  // Fill count never exceeds the list depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  // An accepted request always moves to the compare cycle
  a_acc_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CMP)
    else $error("accepted request did not enter compare");

  // Applying a request always presents a result
  a_apply_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_go |=> out_valid_q)
    else $error("apply without result");

  // A successful insert grows the count by one
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_en |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not increment count");

  // Shifts only happen in the apply cycle, never both at once
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ins_en || cmd.rem_en) |-> (apply_go && !(cmd.ins_en && cmd.rem_en)))
    else $error("shift outside apply");
`endif

endmodule

>>> rtl/slri_cell.sv
// One storage cell of the sorted list chain.
// Holds one entry plus compare flags; shifts with its neighbors on insert/remove.
// Depends on slri_pkg.
module slri_cell #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  slri_pkg::cmd_t        cmd_i,
  input  logic [CntW-1:0]       count_i,
  input  slri_pkg::cell_out_t   left_i,
  input  slri_pkg::cell_out_t   right_i,
  output slri_pkg::cell_out_t   cell_o
);
  import slri_pkg::*;

  localparam logic [CntW-1:0] Idx = CntW'(INDEX);

  logic signed [31:0] entry_q, entry_d;
  logic               gt_q, eq_q;
  logic               occ, at_end;

  // Position relative to the fill level
  assign occ    = Idx < count_i;
  assign at_end = Idx == count_i;

  // Compare flags, taken in the compare cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      gt_q <= entry_q > cmd_i.value;
      eq_q <= entry_q == cmd_i.value;
    end
  end

  // Shift decision: insert pulls from the left, remove pulls from the right
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && ((occ && gt_q) || at_end)) begin
      entry_d = left_i.gt_occ ? left_i.entry : cmd_i.value;
    end else if (cmd_i.rem_en && occ && (gt_q || eq_q)) begin
      entry_d = right_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign cell_o.gt_occ = occ && gt_q;
  assign cell_o.eq_occ = occ && eq_q;
  assign cell_o.entry  = entry_q;

endmodule

>>> tb/sorted_list_insert_remove_test.sv
// Testbench for the sorted list insert/remove block: random insert and remove traffic
// checked against a behavioral copy of the list, with random source and sink stalls.
// Depends on slri_pkg and sorted_list_insert_remove.
module sorted_list_insert_remove_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slri_pkg::*;

  localparam int DEPTH = 16;
  localparam int NUM_RANDOM_REQS = 1600;
  localparam int QUIET_LIMIT = 2000;   // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 100;    // long sink hold-off to back up the input
  localparam int HOLD_AFTER_RSPS = 300;
  localparam int MAX_PRINTED = 20;

  // Sink stall behaviors
  typedef enum int {
    STALL_NONE,
    STALL_SOME,
    STALL_MOST,
    STALL_TOGGLE,
    STALL_HOLD
  } stall_mode_e;

  // Keeps a copy of the list, predicts each response and checks what comes out
  class sorted_list_scoreboard;
    logic signed [31:0] entries [DEPTH];
    int unsigned        fill;
    rsp_t               expected_q [$];
    int unsigned        errors;
    int unsigned        num_checked;

    function new();
      fill = 0;
      errors = 0;
      num_checked = 0;
    endfunction

    // Apply an accepted request to the list copy and queue the response it earns
    function void note_request(req_t req);
      rsp_t        rsp;
      int unsigned pos;

      pos = 0;
      if (req.req_type == REQ_INSERT) begin
        if (fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          // new word goes after every entry equal to it
          while (pos < fill && !(entries[pos] > req.value)) pos++;
          for (int k = fill; k > pos; k--) entries[k] = entries[k - 1];
          entries[pos] = req.value;
          fill++;
          rsp.status = ST_OK;
        end
      end else begin
        // lowest-placed match is the one removed
        while (pos < fill && entries[pos] != req.value) pos++;
        if (pos >= fill) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos + 1; k < fill; k++) entries[k - 1] = entries[k];
          fill--;
          rsp.status = ST_OK;
        end
      end
      rsp.entry_count = 5'(fill);
      expected_q.push_back(rsp);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t: response %0d: %s got %0d, expected %0d",
                 $realtime, num_checked, what, got, want);
    endtask

    task check_response(rsp_t got);
      rsp_t want;

      if (expected_q.size() == 0) begin
        report_mismatch("unexpected response, status", int'(got.status), -1);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", int'(got.entry_count), int'(want.entry_count));
      end
      num_checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_rsp_o;

  sorted_list_scoreboard sb = new();

  logic signed [31:0] recent_values [$];  // recently inserted words, reused for removes
  bit                 hold_done;

  sorted_list_insert_remove #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one request and hold it until the block takes it
  task send_request(input req_t req);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(req);
    if (req.req_type == REQ_INSERT) begin
      recent_values.push_back(req.value);
      if (recent_values.size() > 32) void'(recent_values.pop_front());
    end
  endtask

  task idle_source(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Mostly small or repeated values so that removes hit and duplicates pile up
  function automatic req_t random_request(input int unsigned insert_pct);
    req_t req;

    req.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
    if (req.req_type == REQ_REMOVE && recent_values.size() > 0 &&
        $urandom_range(0, 9) < 6) begin
      req.value = recent_values[$urandom_range(0, recent_values.size() - 1)];
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: req.value = $urandom;
        3: begin
          case ($urandom_range(0, 3))
            0: req.value = 32'sh8000_0000;
            1: req.value = 32'sh7fff_ffff;
            2: req.value = 32'sh0000_0000;
            default: req.value = 32'shffff_ffff;
          endcase
        end
        default: req.value = $urandom_range(0, 15) - 8;
      endcase
    end
    return req;
  endfunction

  // Source side: directed corner cases, then random bursts
  initial begin : source
    int unsigned sent;
    int unsigned burst;
    int unsigned insert_pct;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // remove on an empty list
    send_request('{REQ_REMOVE, 32'sh0000_0000});
    // extremes and duplicates
    send_request('{REQ_INSERT, 32'sh8000_0000});
    send_request('{REQ_INSERT, 32'sh7fff_ffff});
    send_request('{REQ_INSERT, 32'sh0000_0000});
    send_request('{REQ_INSERT, 32'shffff_ffff});
    send_request('{REQ_INSERT, 32'sh0000_0005});
    send_request('{REQ_INSERT, 32'sh0000_0005});
    send_request('{REQ_INSERT, 32'sh0000_0005});
    send_request('{REQ_REMOVE, 32'sh0000_0005});
    // missing value
    send_request('{REQ_REMOVE, 32'sh0000_0007});
    // fill up, then insert into a full list
    repeat (10) send_request('{REQ_INSERT, $urandom});
    send_request('{REQ_INSERT, 32'sh0000_0001});
    send_request('{REQ_REMOVE, 32'sh7fff_ffff});
    send_request('{REQ_REMOVE, 32'sh8000_0000});

    // random traffic; the insert mix drifts so the list swings between empty and full
    sent = 0;
    while (sent < NUM_RANDOM_REQS) begin
      burst = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 75;
      endcase
      for (int i = 0; i < burst && sent < NUM_RANDOM_REQS; i++) begin
        send_request(random_request(insert_pct));
        sent++;
        if ($urandom_range(0, 7) == 0) idle_source($urandom_range(1, 4));
      end
      if ($urandom_range(0, 3) != 0) idle_source($urandom_range(1, 8));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("sorted_list_insert_remove test passed");
    else
      $display("sorted_list_insert_remove test failed");
    $finish;
  end

  // Sink side: random stall segments, plus one long hold-off mid-run
  initial begin : sink
    stall_mode_e mode;
    int unsigned seg_len;
    int unsigned period;
    logic        stall;

    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 120);
      period  = $urandom_range(2, 5);
      if (!hold_done && sb.num_checked >= HOLD_AFTER_RSPS) begin
        mode      = STALL_HOLD;
        seg_len   = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          STALL_NONE:   stall = 1'b0;
          STALL_SOME:   stall = ($urandom_range(0, 1) == 0);
          STALL_MOST:   stall = ($urandom_range(0, 99) < 85);
          STALL_TOGGLE: stall = ((i / period) % 2 == 1);
          default:      stall = 1'b1;
        endcase
        @(negedge clk_i);
        out_stall_i <= stall;
      end
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_response(out_rsp_o);
  end

  // Watchdog: ends the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;

    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("sorted_list_insert_remove test failed");
    $finish;
  end

endmodule
